// ===== src/bcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants
// Frame layout constants, configuration record and response request record
// for the framed record receiver.
// ----------------------------------------------------------------------------
package bcc_pkg;

   localparam int PAYLOAD_BYTES = 24;

   // Frame position: 0 is hunting, then length, command, payload, check, end
   localparam int POS_W = 6;
   localparam logic [POS_W-1:0] POS_HUNT    = POS_W'(0);
   localparam logic [POS_W-1:0] POS_LENGTH  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_COMMAND = POS_W'(2);
   localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(3);
   localparam logic [POS_W-1:0] POS_CHECK   = POS_W'(3 + PAYLOAD_BYTES);
   localparam logic [POS_W-1:0] POS_END     = POS_W'(4 + PAYLOAD_BYTES);

   // Response byte index: start, length, command, code, zeros, check, end
   localparam int RSP_BYTES = PAYLOAD_BYTES + 5;
   localparam int RSP_IDX_W = $clog2(RSP_BYTES);
   localparam logic [RSP_IDX_W-1:0] IDX_FIRST   = RSP_IDX_W'(1);
   localparam logic [RSP_IDX_W-1:0] IDX_LENGTH  = RSP_IDX_W'(1);
   localparam logic [RSP_IDX_W-1:0] IDX_COMMAND = RSP_IDX_W'(2);
   localparam logic [RSP_IDX_W-1:0] IDX_CODE    = RSP_IDX_W'(3);
   localparam logic [RSP_IDX_W-1:0] IDX_CHECK   = RSP_IDX_W'(PAYLOAD_BYTES + 3);
   localparam logic [RSP_IDX_W-1:0] IDX_END     = RSP_IDX_W'(PAYLOAD_BYTES + 4);

   localparam logic [7:0] LENGTH_BYTE = 8'(PAYLOAD_BYTES);

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_CODE       = 3'd0,
      CSR_END_CODE         = 3'd1,
      CSR_EXPECTED_COMMAND = 3'd2,
      CSR_ACK_CODE         = 3'd3,
      CSR_NACK_CODE        = 3'd4
   } csr_index_type;

   localparam logic [7:0] START_CODE_RST       = 8'd1;
   localparam logic [7:0] END_CODE_RST         = 8'd3;
   localparam logic [7:0] EXPECTED_COMMAND_RST = 8'd4;
   localparam logic [7:0] ACK_CODE_RST         = 8'd6;
   localparam logic [7:0] NACK_CODE_RST        = 8'd21;

   typedef struct packed {
      logic [7:0] start_code;
      logic [7:0] end_code;
      logic [7:0] expected_command;
      logic [7:0] ack_code;
      logic [7:0] nack_code;
   } cfg_type;

   // Parser to response sequencer
   typedef struct packed {
      logic start;
      logic ok;
   } burst_req_type;

endpackage

// ===== src/bcc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_if: stream channels of the framed record receiver
// Received-byte channel and response-byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       frame_ok;
   logic       last_byte;

   modport source (output valid, output tx_byte, output frame_ok, output last_byte,
                   input ready);
   modport sink   (input valid, input tx_byte, input frame_ok, input last_byte,
                   output ready);
endinterface

// ===== src/bcc_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_csr: configuration registers
// Holds start, end, command, ACK and NACK codes; writes to unused indexes
// are dropped.
// ----------------------------------------------------------------------------
module bcc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [bcc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [7:0]                         csr_wdata,
   output bcc_pkg::cfg_type                   cfg
);

   bcc_pkg::cfg_type cfg_ff;
   bcc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (bcc_pkg::csr_index_type'(csr_index))
            bcc_pkg::CSR_START_CODE:       cfg_in.start_code       = csr_wdata;
            bcc_pkg::CSR_END_CODE:         cfg_in.end_code         = csr_wdata;
            bcc_pkg::CSR_EXPECTED_COMMAND: cfg_in.expected_command = csr_wdata;
            bcc_pkg::CSR_ACK_CODE:         cfg_in.ack_code         = csr_wdata;
            bcc_pkg::CSR_NACK_CODE:        cfg_in.nack_code        = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_code       <= bcc_pkg::START_CODE_RST;
         cfg_ff.end_code         <= bcc_pkg::END_CODE_RST;
         cfg_ff.expected_command <= bcc_pkg::EXPECTED_COMMAND_RST;
         cfg_ff.ack_code         <= bcc_pkg::ACK_CODE_RST;
         cfg_ff.nack_code        <= bcc_pkg::NACK_CODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/bcc_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_parser: receive frame tracker
// Hunts for the start code, checks length and command, keeps the XOR block
// check and requests a response burst on a good end code.
// ----------------------------------------------------------------------------
module bcc_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  bcc_pkg::cfg_type         cfg,
   input  logic                     in_valid,
   input  logic [7:0]               in_byte,
   output logic                     in_ready,
   input  logic                     burst_free,
   output bcc_pkg::burst_req_type   burst
);

   logic [bcc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0]                run_chk_ff, run_chk_in;
   logic [7:0]                rcv_chk_ff, rcv_chk_in;
   logic                      take;

   // The end byte may launch a burst, so hold it until the sequencer is free
   assign in_ready = (pos_ff != bcc_pkg::POS_END) || burst_free;
   assign take     = in_valid && in_ready;

   always_comb begin
      pos_in      = pos_ff;
      run_chk_in  = run_chk_ff;
      rcv_chk_in  = rcv_chk_ff;
      burst.start = 1'b0;
      burst.ok    = (run_chk_ff == rcv_chk_ff);
      if (take) begin
         pos_in      = pos_ff + bcc_pkg::POS_W'(1);
         if (pos_ff == bcc_pkg::POS_HUNT || pos_ff > bcc_pkg::POS_END) begin
            if (in_byte == cfg.start_code) begin
               pos_in     = bcc_pkg::POS_LENGTH;
               run_chk_in = in_byte;
               rcv_chk_in = 8'd0;
            end else begin
               pos_in     = bcc_pkg::POS_HUNT;
               run_chk_in = 8'd0;
               rcv_chk_in = 8'd0;
            end
         end else if (pos_ff == bcc_pkg::POS_LENGTH) begin
            run_chk_in = run_chk_ff ^ in_byte;
            if (in_byte != bcc_pkg::LENGTH_BYTE) begin
               pos_in     = bcc_pkg::POS_HUNT;
               run_chk_in = 8'd0;
               rcv_chk_in = 8'd0;
            end
         end else if (pos_ff == bcc_pkg::POS_COMMAND) begin
            run_chk_in = run_chk_ff ^ in_byte;
            if (in_byte != cfg.expected_command) begin
               pos_in     = bcc_pkg::POS_HUNT;
               run_chk_in = 8'd0;
               rcv_chk_in = 8'd0;
            end
         end else if (pos_ff < bcc_pkg::POS_CHECK) begin
            run_chk_in = run_chk_ff ^ in_byte;
         end else if (pos_ff == bcc_pkg::POS_CHECK) begin
            rcv_chk_in = in_byte;
         end else begin
            // end position: launch the response only on the end code
            burst.start = (in_byte == cfg.end_code);
            pos_in      = bcc_pkg::POS_HUNT;
            run_chk_in  = 8'd0;
            rcv_chk_in  = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= bcc_pkg::POS_HUNT;
         run_chk_ff <= 8'd0;
         rcv_chk_ff <= 8'd0;
      end else begin
         pos_ff     <= pos_in;
         run_chk_ff <= run_chk_in;
         rcv_chk_ff <= rcv_chk_in;
      end
   end

endmodule

// ===== src/bcc_responder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_responder: response frame sequencer
// Steps a byte index through the response frame and holds each byte in the
// output register until its transfer.
// ----------------------------------------------------------------------------
module bcc_responder (
   input  logic                     clock,
   input  logic                     reset,
   input  bcc_pkg::cfg_type         cfg,
   input  bcc_pkg::burst_req_type   burst,
   output logic                     burst_free,
   bcc_rsp_if.source                rsp
);

   logic                          valid_ff;
   logic [7:0]                    byte_ff, byte_in;
   logic                          last_ff;
   logic                          ok_ff;
   logic [bcc_pkg::RSP_IDX_W-1:0] idx_ff;
   logic [7:0]                    code;
   logic                          xfer;

   assign xfer       = valid_ff && rsp.ready;
   assign burst_free = !valid_ff || (rsp.ready && last_ff);
   assign code       = ok_ff ? cfg.ack_code : cfg.nack_code;

   always_comb begin
      if (idx_ff == bcc_pkg::IDX_LENGTH) begin
         byte_in = bcc_pkg::LENGTH_BYTE;
      end else if (idx_ff == bcc_pkg::IDX_COMMAND) begin
         byte_in = cfg.expected_command;
      end else if (idx_ff == bcc_pkg::IDX_CODE) begin
         byte_in = code;
      end else if (idx_ff == bcc_pkg::IDX_CHECK) begin
         byte_in = cfg.start_code ^ bcc_pkg::LENGTH_BYTE ^ cfg.expected_command ^ code;
      end else if (idx_ff == bcc_pkg::IDX_END) begin
         byte_in = cfg.end_code;
      end else begin
         byte_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
         ok_ff    <= 1'b0;
         idx_ff   <= '0;
         byte_ff  <= 8'd0;
      end else if (burst.start) begin
         valid_ff <= 1'b1;
         byte_ff  <= cfg.start_code;
         last_ff  <= 1'b0;
         ok_ff    <= burst.ok;
         idx_ff   <= bcc_pkg::IDX_FIRST;
      end else if (xfer && !last_ff) begin
         // advance to the next frame byte
         byte_ff <= byte_in;
         last_ff <= (idx_ff == bcc_pkg::IDX_END);
         idx_ff  <= idx_ff + bcc_pkg::RSP_IDX_W'(1);
      end else if (xfer) begin
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.tx_byte   = byte_ff;
   assign rsp.frame_ok  = ok_ff;
   assign rsp.last_byte = last_ff;

endmodule

// ===== src/bcc_framed_record_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_framed_record_receiver: XOR block check framed record receiver
// Parses received bytes into frames and answers each good frame with an
// ACK or NACK response frame.
// ----------------------------------------------------------------------------
//  port    direction  contents
//  req     in         rx_byte, one received byte per transfer
//  rsp     out        tx_byte, frame_ok, last_byte, one response byte each
//  csr_*   in         write enable, register index, 8-bit write data
//
// A received byte is taken every cycle; the end byte of a frame is held
// off while the previous response frame still has a byte waiting, unless its
// last byte transfers in that cycle. A response frame is PAYLOAD_BYTES + 5
// bytes, the first shown in the cycle after the end byte is taken, then one
// byte per cycle while rsp.ready is high. Reset is synchronous and returns
// all codes to their defaults and the parser to hunting.
// ----------------------------------------------------------------------------
module bcc_framed_record_receiver (
   input  logic                            clock,
   input  logic                            reset,
   bcc_req_if.sink                         req,
   bcc_rsp_if.source                       rsp,
   input  logic                            csr_we,
   input  logic [bcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_wdata
);

   bcc_pkg::cfg_type       cfg;
   bcc_pkg::burst_req_type burst;
   logic                   burst_free;

   bcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bcc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req.valid),
      .in_byte    (req.rx_byte),
      .in_ready   (req.ready),
      .burst_free (burst_free),
      .burst      (burst)
   );

   bcc_responder u_responder (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .burst      (burst),
      .burst_free (burst_free),
      .rsp        (rsp)
   );

endmodule

// ===== dv/bcc_framed_record_receiver_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_framed_record_receiver_checker: response predictor and scoreboard
// Follows every received-byte transfer and register write, predicts the
// response frame each good end byte must produce, and compares each
// response transfer field by field against the oldest predicted byte.
// ----------------------------------------------------------------------------
module bcc_framed_record_receiver_checker
   import bcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   bcc_req_if                     req,
   bcc_rsp_if                     rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   output int                     errors,
   output int                     pending
);

   localparam int PRINT_LIMIT = 50;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_ok;
      logic       last_byte;
   } tx_beat_type;

   cfg_type          cfg;
   logic [POS_W-1:0] frame_pos;
   logic [7:0]       frame_bcc;
   logic [7:0]       sender_bcc;
   tx_beat_type      expected_tx[$];

   initial begin
      errors  = 0;
      pending = 0;
   end

   task automatic report_error(input string msg);
      if (errors < PRINT_LIMIT) begin
         $display("%0t ns: %s", $time, msg);
      end
      errors++;
   endtask

   task automatic restart_hunt();
      frame_pos  = POS_HUNT;
      frame_bcc  = 8'h00;
      sender_bcc = 8'h00;
   endtask

   task automatic push_beat(input logic [7:0] b, input logic ok, input logic last);
      tx_beat_type t;
      t.tx_byte   = b;
      t.frame_ok  = ok;
      t.last_byte = last;
      expected_tx.push_back(t);
   endtask

   task automatic queue_response();
      logic       ok;
      logic [7:0] code;
      logic [7:0] bcc;
      int         i;
      ok   = (frame_bcc == sender_bcc);
      code = ok ? cfg.ack_code : cfg.nack_code;
      bcc  = cfg.start_code ^ LENGTH_BYTE ^ cfg.expected_command ^ code;
      push_beat(cfg.start_code, ok, 1'b0);
      push_beat(LENGTH_BYTE, ok, 1'b0);
      push_beat(cfg.expected_command, ok, 1'b0);
      push_beat(code, ok, 1'b0);
      for (i = 1; i < PAYLOAD_BYTES; i++) begin
         push_beat(8'h00, ok, 1'b0);
      end
      push_beat(bcc, ok, 1'b0);
      push_beat(cfg.end_code, ok, 1'b1);
   endtask

   task automatic parse_rx_byte(input logic [7:0] b);
      if (frame_pos == POS_HUNT || frame_pos > POS_END) begin
         if (b == cfg.start_code) begin
            frame_pos  = POS_LENGTH;
            frame_bcc  = b;
            sender_bcc = 8'h00;
         end else begin
            restart_hunt();
         end
      end else if (frame_pos == POS_LENGTH || frame_pos == POS_COMMAND) begin
         // drop the frame on a bad length or command; the byte is consumed
         if (b != ((frame_pos == POS_LENGTH) ? LENGTH_BYTE : cfg.expected_command)) begin
            restart_hunt();
         end else begin
            frame_bcc ^= b;
            frame_pos++;
         end
      end else if (frame_pos < POS_CHECK) begin
         frame_bcc ^= b;
         frame_pos++;
      end else if (frame_pos == POS_CHECK) begin
         sender_bcc = b;
         frame_pos++;
      end else begin
         if (b == cfg.end_code) begin
            queue_response();
         end
         restart_hunt();
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] data);
      case (idx)
         CSR_START_CODE:       cfg.start_code       = data;
         CSR_END_CODE:         cfg.end_code         = data;
         CSR_EXPECTED_COMMAND: cfg.expected_command = data;
         CSR_ACK_CODE:         cfg.ack_code         = data;
         CSR_NACK_CODE:        cfg.nack_code        = data;
         default: ;
      endcase
   endtask

   task automatic check_tx_beat();
      tx_beat_type want;
      if (expected_tx.size() == 0) begin
         report_error($sformatf("response transfer 0x%02h with nothing pending", rsp.tx_byte));
      end else begin
         want = expected_tx.pop_front();
         if (rsp.tx_byte !== want.tx_byte) begin
            report_error($sformatf("tx_byte got 0x%02h, expected 0x%02h",
                                   rsp.tx_byte, want.tx_byte));
         end
         if (rsp.frame_ok !== want.frame_ok) begin
            report_error($sformatf("frame_ok got %b, expected %b", rsp.frame_ok, want.frame_ok));
         end
         if (rsp.last_byte !== want.last_byte) begin
            report_error($sformatf("last_byte got %b, expected %b",
                                   rsp.last_byte, want.last_byte));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg = '{start_code:       START_CODE_RST,
                 end_code:         END_CODE_RST,
                 expected_command: EXPECTED_COMMAND_RST,
                 ack_code:         ACK_CODE_RST,
                 nack_code:        NACK_CODE_RST};
         restart_hunt();
         expected_tx.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            check_tx_beat();
         end
         if (csr_we) begin
            write_register(csr_index, csr_wdata);
         end
         if (req.valid && req.ready) begin
            parse_rx_byte(req.rx_byte);
         end
      end
      pending = expected_tx.size();
   end

endmodule

// ===== dv/bcc_framed_record_receiver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_framed_record_receiver_tb: top of the framed record receiver bench
// Drives directed and random frames (good, bad check, bad length, bad
// command, bad end, cut short, noise) through several code settings and
// handshake pressure levels; the checker predicts and scores the responses.
// ----------------------------------------------------------------------------
module bcc_framed_record_receiver_tb;
   import bcc_pkg::*;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_CHECK,
      FRAME_BAD_LENGTH,
      FRAME_BAD_COMMAND,
      FRAME_BAD_END,
      FRAME_CUT,
      FRAME_NOISE
   } frame_kind_type;

   localparam int RESET_CYCLES    = 10;
   localparam int SETTLE_CYCLES   = 40;
   localparam int PHASE_BYTES     = 10;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int FLUSH_BYTES     = 29;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0]             csr_wdata;

   int      check_errors;
   int      check_pending;
   int      src_idle_pct   = 0;
   int      sink_stall_pct = 0;
   int      hold_left      = 0;
   int      sent_bytes     = 0;
   cfg_type link_cfg;

   bcc_req_if req_ch ();
   bcc_rsp_if rsp_ch ();

   bcc_framed_record_receiver dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bcc_framed_record_receiver_checker resp_check (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .errors    (check_errors),
      .pending   (check_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Response side: long hold when requested, random stalls otherwise
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid   = 1'b1;
      req_ch.rx_byte = b;
      do @(posedge clock); while (!req_ch.ready);
      sent_bytes++;
   endtask

   task automatic release_req();
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   function automatic logic [7:0] pick_other(input logic [7:0] a);
      logic [7:0] v;
      v = 8'($urandom);
      while (v == a) v = 8'($urandom);
      return v;
   endfunction

   // fill < 0: random payload; odd >= 0: forced wrong length or end byte
   task automatic send_frame(input frame_kind_type kind, input int fill, input int odd);
      logic [7:0] pkt[$];
      logic [7:0] bcc;
      logic [7:0] b;
      int         cut;
      int         i;
      if (kind == FRAME_NOISE) begin
         cut = $urandom_range(1, 4);
         for (i = 0; i < cut; i++) begin
            pkt.push_back(($urandom_range(7) == 0) ? link_cfg.start_code : 8'($urandom));
         end
      end else begin
         pkt.push_back(link_cfg.start_code);
         if (kind == FRAME_BAD_LENGTH) begin
            pkt.push_back((odd >= 0) ? 8'(odd) : pick_other(LENGTH_BYTE));
         end else begin
            pkt.push_back(LENGTH_BYTE);
            if (kind == FRAME_BAD_COMMAND) begin
               pkt.push_back(pick_other(link_cfg.expected_command));
            end else begin
               pkt.push_back(link_cfg.expected_command);
               bcc = link_cfg.start_code ^ LENGTH_BYTE ^ link_cfg.expected_command;
               cut = (kind == FRAME_CUT) ? $urandom_range(0, PAYLOAD_BYTES - 1) : PAYLOAD_BYTES;
               for (i = 0; i < cut; i++) begin
                  b = (fill < 0) ? 8'($urandom) : 8'(fill);
                  pkt.push_back(b);
                  bcc ^= b;
               end
               if (kind != FRAME_CUT) begin
                  pkt.push_back((kind == FRAME_BAD_CHECK) ?
                                (bcc ^ 8'($urandom_range(1, 255))) : bcc);
                  if (kind == FRAME_BAD_END) begin
                     pkt.push_back((odd >= 0) ? 8'(odd) : pick_other(link_cfg.end_code));
                  end else begin
                     pkt.push_back(link_cfg.end_code);
                  end
               end
            end
         end
      end
      foreach (pkt[i]) send_byte(pkt[i]);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic configure(input logic [7:0] s, input logic [7:0] e, input logic [7:0] c,
                            input logic [7:0] a, input logic [7:0] n);
      write_csr(CSR_START_CODE, s);
      write_csr(CSR_END_CODE, e);
      write_csr(CSR_EXPECTED_COMMAND, c);
      write_csr(CSR_ACK_CODE, a);
      write_csr(CSR_NACK_CODE, n);
      // an index past the register list must leave the codes alone
      write_csr(CSR_INDEX_W'($urandom_range(5, 7)), 8'($urandom));
      link_cfg = '{start_code: s, end_code: e, expected_command: c, ack_code: a, nack_code: n};
   endtask

   // Stop offering bytes and wait until the responses drain
   task automatic drain();
      release_req();
      while (check_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Push the parser back to hunting, then wait until the responses drain
   task automatic settle();
      logic [7:0] v;
      int         i;
      v = 8'($urandom);
      while (v == link_cfg.start_code || v == link_cfg.end_code ||
             v == link_cfg.expected_command || v == LENGTH_BYTE) begin
         v = 8'($urandom);
      end
      for (i = 0; i < FLUSH_BYTES; i++) send_byte(v);
      drain();
   endtask

   task automatic random_phase();
      int first;
      int r;
      first = sent_bytes;
      while (sent_bytes - first < PHASE_BYTES) begin
         r = $urandom_range(99);
         if (r < 55)      send_frame(FRAME_GOOD, -1, -1);
         else if (r < 70) send_frame(FRAME_BAD_CHECK, -1, -1);
         else if (r < 76) send_frame(FRAME_BAD_LENGTH, -1, -1);
         else if (r < 82) send_frame(FRAME_BAD_COMMAND, -1, -1);
         else if (r < 88) send_frame(FRAME_BAD_END, -1, -1);
         else if (r < 93) send_frame(FRAME_CUT, -1, -1);
         else             send_frame(FRAME_NOISE, -1, -1);
      end
   endtask

   initial begin
      int ph;
      int n;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = 8'h00;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      link_cfg = '{start_code:       START_CODE_RST,
                   end_code:         END_CODE_RST,
                   expected_command: EXPECTED_COMMAND_RST,
                   ack_code:         ACK_CODE_RST,
                   nack_code:        NACK_CODE_RST};
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part on the reset codes
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(FRAME_GOOD, 8'hFF, -1);
      send_frame(FRAME_BAD_CHECK, 8'h00, -1);
      // a bad length equal to the start code must not reopen a frame
      send_frame(FRAME_BAD_LENGTH, -1, START_CODE_RST);
      send_frame(FRAME_BAD_COMMAND, -1, -1);
      // same for a bad end byte equal to the start code
      send_frame(FRAME_BAD_END, -1, START_CODE_RST);
      drain();

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               src_idle_pct   = 0;
               sink_stall_pct = 0;
               configure(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
            end
            1: begin
               src_idle_pct   = 53;
               sink_stall_pct = 0;
               configure(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
            end
            2: begin
               src_idle_pct   = 0;
               sink_stall_pct = 53;
               configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
            default: begin
               src_idle_pct   = 26;
               sink_stall_pct = 26;
               // start code equal to the length byte
               configure(LENGTH_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
         endcase
         random_phase();
         drain();
      end

      // hold the response side so the block fills up and stalls its input
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      configure(START_CODE_RST, END_CODE_RST, EXPECTED_COMMAND_RST, ACK_CODE_RST,
                NACK_CODE_RST);
      settle();
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      repeat (2) send_frame(FRAME_GOOD, -1, -1);
      release_req();

      for (n = 0; n < DRAIN_LIMIT && check_pending != 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (check_errors == 0 && check_pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
